// ----- rtl/ptts_pkg.sv -----
package ptts_pkg;

	localparam int MaxTasks = 4;
	localparam int TaskIdxW = 2;
	localparam int CntW     = 32;
	localparam int RegW     = 16;
	localparam int CfgIdxW  = 3;

	// Register map: periods first, then start delays.
	localparam logic [CfgIdxW-1:0] RegPeriod0 = 3'd0;
	localparam logic [CfgIdxW-1:0] RegDelay0  = 3'd4;

	typedef enum logic [1:0] {
		OP_RESTART = 2'd0,
		OP_TICK    = 2'd1,
		OP_SUSPEND = 2'd2,
		OP_SLEEP   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_ACK
	} state_t;

	// Command broadcast to every cell when a request is accepted.
	typedef struct packed {
		logic                restart;
		logic                suspend;
		logic                sleep;
		logic [TaskIdxW-1:0] task_index;
		logic [RegW-1:0]     ticks;
	} cmd_t;

	// What a cell reports about the scan token it holds.
	typedef struct packed {
		logic tok;
		logic fire;
		logic last;
	} cell_stat_t;

endpackage

// ----- rtl/ptts_cell.sv -----
module ptts_cell #(
	parameter int IDX = 0
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ptts_pkg::cmd_t          cmd,
	input  logic                    shift,
	input  logic                    tok_in,
	input  logic                    later_in,
	input  logic [ptts_pkg::RegW-1:0] period,
	input  logic [ptts_pkg::RegW-1:0] delay,
	output logic                    tok_out,
	output logic                    later_out,
	output ptts_pkg::cell_stat_t    stat
);

	logic [ptts_pkg::CntW-1:0] cd_q;
	logic                      running_q;
	logic                      tok_q;
	logic                      sel;
	logic                      pend;
	logic [ptts_pkg::CntW:0]   sum;
	logic [ptts_pkg::CntW-1:0] reload;

	assign sel    = (cmd.task_index == ptts_pkg::TaskIdxW'(IDX));
	assign pend   = running_q && (cd_q == '0);
	assign sum    = {1'b0, cd_q} + {{(ptts_pkg::CntW + 1 - ptts_pkg::RegW){1'b0}}, cmd.ticks};
	// A zero period behaves as period one, so the reload after the decrement is zero.
	assign reload = (period == '0) ? '0
		: {{(ptts_pkg::CntW - ptts_pkg::RegW){1'b0}}, period - ptts_pkg::RegW'(1)};

	assign tok_out   = tok_q;
	assign later_out = later_in | pend;
	assign stat.tok  = tok_q;
	assign stat.fire = tok_q && pend;
	assign stat.last = !later_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cd_q      <= '0;
			running_q <= 1'b0;
			tok_q     <= 1'b0;
		end else begin
			if (shift) begin
				tok_q <= tok_in;
			end
			if (cmd.restart) begin
				cd_q      <= {{(ptts_pkg::CntW - ptts_pkg::RegW){1'b0}}, delay};
				running_q <= 1'b1;
			end else if (cmd.suspend && sel) begin
				running_q <= 1'b0;
			end else if (cmd.sleep && sel) begin
				cd_q <= sum[ptts_pkg::CntW] ? '1 : sum[ptts_pkg::CntW-1:0];
			end else if (shift && tok_q && running_q) begin
				cd_q <= pend ? reload : cd_q - ptts_pkg::CntW'(1);
			end
		end
	end

endmodule

// ----- rtl/periodic_task_tick_scheduler.sv -----
// Restart, suspend and sleep requests update the cells in the accept cycle. Their single
// acknowledgement is loaded from the ACK state, and the next request is taken after that.
// A tick request walks a token down the row of task cells, one cell per cycle while the
// output register is free, and the next request is taken once the token has left the last cell.
// A release is loaded as the token passes a cell that fires. Both kinds take longer while the output stalls.
// Reset clears all countdowns, stops every task, sets periods to 1 and delays to 0.
module periodic_task_tick_scheduler #(
	parameter int TASKS = ptts_pkg::MaxTasks
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        op,
	input  logic [ptts_pkg::TaskIdxW-1:0]     task_index,
	input  logic [ptts_pkg::RegW-1:0]         sleep_ticks,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [ptts_pkg::TaskIdxW-1:0]     fire_task,
	output logic                              fired,
	output logic                              last_of_run,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ptts_pkg::CfgIdxW-1:0]      cfg_index,
	input  logic [ptts_pkg::RegW-1:0]         cfg_data
);

	// Configuration registers. Entries for tasks beyond TASKS are stored but
	// never read by a cell.
	logic [ptts_pkg::RegW-1:0] period_q [ptts_pkg::MaxTasks];
	logic [ptts_pkg::RegW-1:0] delay_q  [ptts_pkg::MaxTasks];

	ptts_pkg::state_t st_q, st_d;

	logic                          in_acc;
	logic                          slot_free;
	logic                          adv;
	logic                          start;
	logic                          shift;
	ptts_pkg::cmd_t                cmd;
	ptts_pkg::op_t                 op_e;

	logic [TASKS:0]                tok_chain;
	logic [TASKS:0]                later_chain;
	ptts_pkg::cell_stat_t          stat [TASKS];
	logic [TASKS-1:0]              tok_vec;

	logic                          fire_any;
	logic                          last_any;
	logic [ptts_pkg::TaskIdxW-1:0] fire_idx;
	logic                          tok_end;
	logic                          any_fired_q;

	logic                          out_valid_q;
	logic [ptts_pkg::TaskIdxW-1:0] fire_task_q;
	logic                          fired_q;
	logic                          last_q;
	logic                          load;
	logic [ptts_pkg::TaskIdxW-1:0] load_task;
	logic                          load_fired;
	logic                          load_last;

	assign op_e      = ptts_pkg::op_t'(op);
	assign in_ready  = (st_q == ptts_pkg::ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// The output register is free when empty or being emptied this cycle.
	assign slot_free = !out_valid_q || out_ready;
	assign adv       = (st_q == ptts_pkg::ST_SCAN) && slot_free;
	assign start     = in_acc && (op_e == ptts_pkg::OP_TICK);
	assign shift     = adv || start;

	assign cmd.restart    = in_acc && (op_e == ptts_pkg::OP_RESTART);
	assign cmd.suspend    = in_acc && (op_e == ptts_pkg::OP_SUSPEND);
	assign cmd.sleep      = in_acc && (op_e == ptts_pkg::OP_SLEEP);
	assign cmd.task_index = task_index;
	assign cmd.ticks      = sleep_ticks;

	// The token enters the first cell when a tick is accepted. The pending
	// chain runs backward so that each cell knows whether a later task fires.
	assign tok_chain[0]       = start;
	assign later_chain[TASKS] = 1'b0;

	for (genvar i = 0; i < TASKS; i++) begin : g_cell
		ptts_cell #(
			.IDX(i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.shift    (shift),
			.tok_in   (tok_chain[i]),
			.later_in (later_chain[i+1]),
			.period   (period_q[i]),
			.delay    (delay_q[i]),
			.tok_out  (tok_chain[i+1]),
			.later_out(later_chain[i]),
			.stat     (stat[i])
		);
		assign tok_vec[i] = stat[i].tok;
	end

	// Only the cell holding the token can fire, so an OR encodes its index.
	always_comb begin
		fire_any = 1'b0;
		last_any = 1'b0;
		fire_idx = '0;
		for (int i = 0; i < TASKS; i++) begin
			fire_any = fire_any | stat[i].fire;
			last_any = last_any | (stat[i].fire & stat[i].last);
			fire_idx = fire_idx | (stat[i].fire ? ptts_pkg::TaskIdxW'(i) : '0);
		end
	end

	assign tok_end = tok_chain[TASKS];

	// State register and next-state / output-load logic.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ptts_pkg::ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d       = st_q;
		load       = 1'b0;
		load_task  = '0;
		load_fired = 1'b0;
		load_last  = 1'b1;
		unique case (st_q)
			ptts_pkg::ST_IDLE: begin
				if (in_acc) begin
					st_d = start ? ptts_pkg::ST_SCAN : ptts_pkg::ST_ACK;
				end
			end
			ptts_pkg::ST_SCAN: begin
				if (adv) begin
					if (fire_any) begin
						load       = 1'b1;
						load_task  = fire_idx;
						load_fired = 1'b1;
						load_last  = last_any;
					end else if (tok_end && !any_fired_q) begin
						// A tick that released nothing is acknowledged once.
						load = 1'b1;
					end
					if (tok_end) begin
						st_d = ptts_pkg::ST_IDLE;
					end
				end
			end
			ptts_pkg::ST_ACK: begin
				if (slot_free) begin
					load = 1'b1;
					st_d = ptts_pkg::ST_IDLE;
				end
			end
			default: begin
				st_d = ptts_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_fired_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (start) begin
				any_fired_q <= 1'b0;
			end else if (adv && fire_any) begin
				any_fired_q <= 1'b1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			fire_task_q <= load_task;
			fired_q     <= load_fired;
			last_q      <= load_last;
		end
	end

	// Configuration writes: periods below the delay bank, delays above it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ptts_pkg::MaxTasks; i++) begin
				period_q[i] <= ptts_pkg::RegW'(1);
				delay_q[i]  <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index < ptts_pkg::RegDelay0) begin
				period_q[cfg_index[ptts_pkg::TaskIdxW-1:0]] <= cfg_data;
			end else begin
				delay_q[cfg_index[ptts_pkg::TaskIdxW-1:0]] <= cfg_data;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign fire_task   = fire_task_q;
	assign fired       = fired_q;
	assign last_of_run = last_q;

	// At most one cell holds the scan token.
	a_tok_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_vec))
		else $error("scan token held by more than one cell");

	// No token travels while the scheduler waits for a request.
	a_idle_no_tok: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ptts_pkg::ST_IDLE) |-> (tok_vec == '0))
		else $error("scan token present while idle");

	// An accepted tick puts the token into the first cell.
	a_tick_starts: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> (tok_vec[0] && st_q == ptts_pkg::ST_SCAN))
		else $error("tick did not start a scan");

	// A result is loaded only into a free output register.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> slot_free)
		else $error("result overwrote a pending result");

endmodule

// ----- test/tb_top.sv -----
module tb_top;

	localparam int NumTasks   = ptts_pkg::MaxTasks;
	localparam int NumRegs    = 8;
	localparam int IdxW       = ptts_pkg::TaskIdxW;
	localparam int DataW      = ptts_pkg::RegW;
	localparam int CountW     = ptts_pkg::CntW;
	localparam int CfgW       = ptts_pkg::CfgIdxW;
	// Long output hold-off used to fill the scheduler and back up its input.
	localparam int HoldCycles = 150;
	// Generous bound, far above what the whole run takes even when the receiver
	// stalls most of the time and every tick releases all tasks.
	localparam int CycleLimit = 100000;

	// One result of the scheduler as seen on the output channel.
	typedef struct packed {
		logic [IdxW-1:0] task_id;
		logic            real_release;
		logic            closes_run;
	} release_t;

	logic             clk         = 1'b0;
	logic             arst_n      = 1'b0;
	logic             in_valid    = 1'b0;
	logic             in_ready;
	logic [1:0]       op          = ptts_pkg::OP_RESTART;
	logic [IdxW-1:0]  task_index  = '0;
	logic [DataW-1:0] sleep_ticks = '0;
	logic             out_valid;
	logic             out_ready   = 1'b0;
	logic [IdxW-1:0]  fire_task;
	logic             fired;
	logic             last_of_run;
	logic             cfg_valid   = 1'b0;
	logic             cfg_ready;
	logic [CfgW-1:0]  cfg_index   = '0;
	logic [DataW-1:0] cfg_data    = '0;

	periodic_task_tick_scheduler dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.task_index  (task_index),
		.sleep_ticks (sleep_ticks),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.fire_task   (fire_task),
		.fired       (fired),
		.last_of_run (last_of_run),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #5 clk = ~clk;

	// Shadow copy of the scheduler: configuration and per-task timing state.
	logic [DataW-1:0]  period_shadow [NumTasks];
	logic [DataW-1:0]  delay_shadow  [NumTasks];
	logic [CountW-1:0] ticks_left    [NumTasks];
	logic              task_on       [NumTasks];

	// Releases and acknowledgements still owed by the scheduler, oldest first.
	release_t due_releases [$];

	// Register values to be written by the next call of load_registers.
	logic [DataW-1:0] reg_plan [NumRegs];

	int          fail_count   = 0;
	int          results_seen = 0;
	int unsigned cycle_count  = 0;
	release_t    head;

	// Sender pacing: requests go out in bursts, separated by idle gaps.
	int burst_left = 0;
	int gap_left   = 0;
	bit req_offered = 1'b0;
	// Set by a test to make the receiver start its long hold-off.
	bit hold_go     = 1'b0;

	task automatic report_mismatch(string what, int got, int want);
		fail_count++;
		$display("mismatch on %s of result %0d: got %0d, expected %0d",
			what, results_seen, got, want);
	endtask

	// Works out the results of one accepted request and advances the shadow state.
	// A tick walks the running tasks in index order; a task at zero is reloaded
	// from its period and released, then every running countdown moves down by one.
	task automatic advance_schedule(ptts_pkg::op_t req_op, logic [IdxW-1:0] req_task,
			logic [DataW-1:0] req_ticks);
		release_t        batch [NumTasks];
		release_t        ack;
		int              n;
		logic [CountW:0] sum;
		n = 0;
		case (req_op)
		ptts_pkg::OP_RESTART: begin
			for (int t = 0; t < NumTasks; t++) begin
				ticks_left[t] = CountW'(delay_shadow[t]);
				task_on[t] = 1'b1;
			end
		end
		ptts_pkg::OP_TICK: begin
			for (int t = 0; t < NumTasks; t++) begin
				if (task_on[t]) begin
					if (ticks_left[t] == '0) begin
						// A period register holding zero behaves as a period of one.
						ticks_left[t] = (period_shadow[t] == '0) ?
							CountW'(1) : CountW'(period_shadow[t]);
						batch[n].task_id = IdxW'(t);
						batch[n].real_release = 1'b1;
						batch[n].closes_run = 1'b0;
						n++;
					end
					ticks_left[t] = ticks_left[t] - CountW'(1);
				end
			end
		end
		ptts_pkg::OP_SUSPEND: begin
			if (int'(req_task) < NumTasks)
				task_on[req_task] = 1'b0;
		end
		default: begin
			// Sleep applies whether or not the task runs, and sticks at all ones.
			if (int'(req_task) < NumTasks) begin
				sum = {1'b0, ticks_left[req_task]} + (CountW + 1)'(req_ticks);
				ticks_left[req_task] = sum[CountW] ? '1 : sum[CountW-1:0];
			end
		end
		endcase
		if (n == 0) begin
			ack = '0;
			ack.closes_run = 1'b1;
			due_releases.push_back(ack);
		end else begin
			batch[n-1].closes_run = 1'b1;
			for (int k = 0; k < n; k++)
				due_releases.push_back(batch[k]);
		end
	endtask

	// Offers one request and waits for the scheduler to take it. The payload is
	// driven just after a rising edge and counts as taken at the first edge at
	// which in_ready is seen high. Between bursts valid is dropped for a gap.
	task automatic send_request(ptts_pkg::op_t req_op, logic [IdxW-1:0] req_task,
			logic [DataW-1:0] req_ticks);
		while (gap_left > 0) begin
			gap_left--;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		op          <= req_op;
		task_index  <= req_task;
		sleep_ticks <= req_ticks;
		req_offered = 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		advance_schedule(req_op, req_task, req_ticks);
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			// Mostly short bursts, now and then a long one with no idling at all.
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) :
				$urandom_range(1, 10);
			gap_left = $urandom_range(0, 6);
			if (gap_left > 0) begin
				in_valid <= 1'b0;
				req_offered = 1'b0;
			end
		end
	endtask

	// Brings the scheduler to rest: no request on offer, every owed result
	// delivered, and then a wait for a tick scan that may still be running.
	task automatic settle();
		if (req_offered) begin
			in_valid <= 1'b0;
			req_offered = 1'b0;
		end
		while (due_releases.size() != 0)
			@(posedge clk);
		repeat (NumTasks + 2) @(posedge clk);
	endtask

	// Writes all registers from reg_plan, back to back, keeping the write valid
	// high across the whole sequence.
	task automatic load_registers();
		for (int r = 0; r < NumRegs; r++) begin
			cfg_valid <= 1'b1;
			cfg_index <= CfgW'(r);
			cfg_data  <= reg_plan[r];
			do
				@(posedge clk);
			while (!cfg_ready);
			if (r < ptts_pkg::RegDelay0)
				period_shadow[r - ptts_pkg::RegPeriod0] = reg_plan[r];
			else
				delay_shadow[r - ptts_pkg::RegDelay0] = reg_plan[r];
		end
		cfg_valid <= 1'b0;
	endtask

	// Right after reset every task is stopped and the registers hold their reset
	// values: period one, delay zero. Once restarted, all four tasks fire on
	// every tick, which is the largest number of results one request can cause.
	task automatic test_reset_state();
		send_request(ptts_pkg::OP_TICK, 2'd3, 16'hFFFF);
		send_request(ptts_pkg::OP_SUSPEND, 2'd2, 16'h0000);
		send_request(ptts_pkg::OP_SLEEP, 2'd1, 16'hFFFF);
		send_request(ptts_pkg::OP_RESTART, 2'd0, 16'h0000);
		send_request(ptts_pkg::OP_TICK, 2'd0, 16'h0000);
		send_request(ptts_pkg::OP_TICK, 2'd1, 16'h5A5A);
	endtask

	// Register extremes, suspend, and sleep on running and on suspended tasks.
	task automatic test_directed_cases();
		settle();
		reg_plan[ptts_pkg::RegPeriod0 + 0] = 16'h0000;
		reg_plan[ptts_pkg::RegPeriod0 + 1] = 16'hFFFF;
		reg_plan[ptts_pkg::RegPeriod0 + 2] = 16'h0002;
		reg_plan[ptts_pkg::RegPeriod0 + 3] = 16'h0003;
		reg_plan[ptts_pkg::RegDelay0 + 0]  = 16'hFFFF;
		reg_plan[ptts_pkg::RegDelay0 + 1]  = 16'h0000;
		reg_plan[ptts_pkg::RegDelay0 + 2]  = 16'h0001;
		reg_plan[ptts_pkg::RegDelay0 + 3]  = 16'h0002;
		load_registers();
		send_request(ptts_pkg::OP_RESTART, 2'd3, 16'hFFFF);
		repeat (4) send_request(ptts_pkg::OP_TICK, 2'd0, 16'h0000);
		send_request(ptts_pkg::OP_SUSPEND, 2'd1, 16'h0000);
		send_request(ptts_pkg::OP_SLEEP, 2'd1, 16'h0003);
		send_request(ptts_pkg::OP_SLEEP, 2'd2, 16'h0000);
		send_request(ptts_pkg::OP_SLEEP, 2'd0, 16'h8000);
		send_request(ptts_pkg::OP_SLEEP, 2'd3, 16'h0001);
		repeat (3) send_request(ptts_pkg::OP_TICK, 2'd2, 16'hA5A5);
		send_request(ptts_pkg::OP_RESTART, 2'd0, 16'h0000);
		send_request(ptts_pkg::OP_TICK, 2'd0, 16'h0000);
	endtask

	// With every task firing on every tick, the receiver stops taking results
	// for a long stretch while ticks keep coming, so the scheduler backs up.
	task automatic test_output_backpressure();
		settle();
		for (int r = 0; r < NumRegs; r++)
			reg_plan[r] = (r < ptts_pkg::RegDelay0) ? 16'h0001 : 16'h0000;
		load_registers();
		send_request(ptts_pkg::OP_RESTART, 2'd0, 16'h0000);
		hold_go = 1'b1;
		repeat (16) send_request(ptts_pkg::OP_TICK, 2'd0, 16'h0000);
	endtask

	// Several phases, each with fresh register values. Small periods and delays
	// dominate so that releases happen often; a few values span the full range.
	// Each phase starts with a restart so the tasks actually run.
	task automatic test_random_traffic();
		ptts_pkg::op_t    pick;
		int               roll;
		logic [DataW-1:0] step;
		for (int phase = 0; phase < 4; phase++) begin
			settle();
			for (int r = 0; r < NumRegs; r++)
				reg_plan[r] = ($urandom_range(0, 3) != 0) ?
					DataW'($urandom_range(0, 6)) : DataW'($urandom);
			load_registers();
			send_request(ptts_pkg::OP_RESTART, IdxW'($urandom), DataW'($urandom));
			for (int k = 0; k < 50; k++) begin
				roll = $urandom_range(0, 99);
				if (roll < 55)
					pick = ptts_pkg::OP_TICK;
				else if (roll < 63)
					pick = ptts_pkg::OP_RESTART;
				else if (roll < 75)
					pick = ptts_pkg::OP_SUSPEND;
				else
					pick = ptts_pkg::OP_SLEEP;
				roll = $urandom_range(0, 9);
				if (roll < 6)
					step = DataW'($urandom_range(0, 4));
				else if (roll < 8)
					step = DataW'($urandom);
				else if (roll < 9)
					step = 16'hFFFF;
				else
					step = 16'h0000;
				send_request(pick, IdxW'($urandom_range(0, NumTasks - 1)), step);
			end
		end
	endtask

	// Task 3 starts at 0xFFFF and is pushed far above the 16-bit range by large
	// sleeps, then ticked, slept on while suspended, and restarted.
	task automatic test_sleep_accumulation();
		settle();
		for (int r = 0; r < NumRegs; r++)
			reg_plan[r] = (r < ptts_pkg::RegDelay0) ? 16'h0001 : 16'h0000;
		reg_plan[ptts_pkg::RegDelay0 + 3] = 16'hFFFF;
		load_registers();
		send_request(ptts_pkg::OP_RESTART, 2'd0, 16'h0000);
		repeat (8) send_request(ptts_pkg::OP_SLEEP, 2'd3, 16'hFFFF);
		send_request(ptts_pkg::OP_SLEEP, 2'd2, 16'hFFFF);
		send_request(ptts_pkg::OP_TICK, 2'd0, 16'h0000);
		send_request(ptts_pkg::OP_SLEEP, 2'd3, 16'h0002);
		send_request(ptts_pkg::OP_TICK, 2'd0, 16'h0000);
		send_request(ptts_pkg::OP_SUSPEND, 2'd3, 16'h0000);
		send_request(ptts_pkg::OP_SLEEP, 2'd3, 16'h0010);
		send_request(ptts_pkg::OP_TICK, 2'd0, 16'h0000);
		send_request(ptts_pkg::OP_RESTART, 2'd0, 16'h0000);
		send_request(ptts_pkg::OP_TICK, 2'd0, 16'h0000);
	endtask

	// Receiver: a long hold-off when a test asks for one, otherwise stretches of
	// different stall patterns, including stretches that never stall.
	initial begin : receiver
		int left;
		int style;
		int beat;
		left  = 0;
		style = 0;
		beat  = 0;
		forever begin
			if (hold_go) begin
				hold_go = 1'b0;
				out_ready <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
			end else begin
				if (left == 0) begin
					style = $urandom_range(0, 3);
					left  = $urandom_range(8, 80);
				end
				left--;
				beat++;
				case (style)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				2: out_ready <= (beat % 3) != 0;
				default: out_ready <= ($urandom_range(0, 5) == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	// Result checker: every result taken from the scheduler is matched against
	// the oldest one still owed.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_seen <= results_seen + 1;
			if (due_releases.size() == 0)
				report_mismatch("arrival (nothing owed)", fire_task, -1);
			else begin
				head = due_releases.pop_front();
				if (fire_task !== head.task_id)
					report_mismatch("fire_task", fire_task, head.task_id);
				if (fired !== head.real_release)
					report_mismatch("fired", fired, head.real_release);
				if (last_of_run !== head.closes_run)
					report_mismatch("last_of_run", last_of_run, head.closes_run);
			end
		end
	end

	// Watchdog: a hang anywhere ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	initial begin
		// Shadow state starts from the documented reset values.
		for (int t = 0; t < NumTasks; t++) begin
			period_shadow[t] = 16'h0001;
			delay_shadow[t]  = 16'h0000;
			ticks_left[t]    = '0;
			task_on[t]       = 1'b0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_directed_cases();
		test_output_backpressure();
		test_random_traffic();
		test_sleep_accumulation();

		// Let everything owed arrive, then watch a little longer for strays.
		settle();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
